// ===== hdl/ttcw_pkg.sv =====
// package for the text terminal character writer
// word layouts, operation and register codes, controller states and command/status structs
// no dependencies
package ttcw_pkg;

  // operation kinds carried in the input word
  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_MOVE  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FG   = 2'd0,
    CFG_BG   = 2'd1,
    CFG_BOLD = 2'd2
  } cfg_idx_e;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  // control bytes and blank cell
  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_LF    = 8'd10;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] BLANK_CODE = 8'h20;

  // reset values of the color registers and the matching attribute
  localparam logic [3:0] FG_RESET   = 4'd7;
  localparam logic [3:0] BG_RESET   = 4'd0;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  // tab stops every eight columns
  localparam int TabStep = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] target_row;
    logic [6:0] target_col;
  } in_word_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] scroll_count;
    logic [7:0] cell_code;
    logic [7:0] cell_attribute;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/ttcw_stream_if.sv =====
// valid/ready stream interface used for the input and result channels
// payload type is a parameter, normally a word type from ttcw_pkg
interface ttcw_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/ttcw_ctrl.sv =====
// controller state machine of the text terminal character writer
// depends on ttcw_pkg (state enum, command and status structs)
module ttcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ttcw_pkg::status_t status_i,
  output ttcw_pkg::cmd_t    cmd_o
);

  ttcw_pkg::state_e state_q, state_d;

  // state register, starts with the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttcw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ttcw_pkg::ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) state_d = ttcw_pkg::ST_IDLE;
      end
      ttcw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ttcw_pkg::ST_EXEC;
        end
      end
      ttcw_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.need_sweep ? ttcw_pkg::ST_SWEEP : ttcw_pkg::ST_DONE;
      end
      ttcw_pkg::ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) state_d = ttcw_pkg::ST_DONE;
      end
      ttcw_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ttcw_pkg::ST_IDLE;
        end
      end
      default: state_d = ttcw_pkg::ST_IDLE;
    endcase
  end

  // no word taken while a sweep or an operation is in flight
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ttcw_pkg::ST_IDLE)
    else $error("ready raised outside idle");

  // a result is loaded only when the output slot can take it
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded into a full output slot");

  // an operation always follows an accepted word
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> cmd_o.exec)
    else $error("accepted word not executed");

endmodule

// ===== hdl/ttcw_dp.sv =====
// datapath of the text terminal character writer: config registers, cursor,
// scroll state, cell memory with circular row base, sweep pointer and output register
// depends on ttcw_pkg
module ttcw_dp #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 21,
  parameter int SCROLL_LIMIT = 255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ttcw_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ttcw_pkg::CfgDataW-1:0]   cfg_data_i,
  input  ttcw_pkg::in_word_t              in_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output ttcw_pkg::out_word_t             out_data_o,
  input  ttcw_pkg::cmd_t                  cmd_i,
  output ttcw_pkg::status_t               status_o
);

  localparam int CellCount = ROWS * COLUMNS;
  localparam int AW        = $clog2(CellCount);
  localparam int RW        = $clog2(ROWS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RowNW     = RW + 1;
  localparam int ColNW     = CW + 1;

  // config registers
  logic [3:0] fg_q, bg_q;
  logic       bold_q;
  logic [7:0] cur_attr;

  // item and state registers
  ttcw_pkg::in_word_t  item_q;
  logic [7:0]          attr_q;
  logic [RW-1:0]       cur_row_q;
  logic [CW-1:0]       cur_col_q;
  logic [7:0]          scroll_q;
  logic [RW-1:0]       base_q;
  logic [AW-1:0]       ptr_q;
  logic [AW-1:0]       sweep_end_q;
  ttcw_pkg::out_word_t out_q;
  logic                out_valid_q;

  // cell memory, attribute in the upper byte
  logic [15:0] mem [CellCount];
  logic [15:0] rd_q;

  // put-character evaluation
  logic [RowNW-1:0] put_row_n;
  logic [ColNW-1:0] put_col_n;
  logic             put_we;
  logic [CW-1:0]    put_wcol;
  logic [7:0]       put_code;
  logic             put_scroll;

  // addressing
  logic [RW-1:0]    rd_row;
  logic [CW-1:0]    rd_col;
  logic [RW-1:0]    a_row;
  logic [CW-1:0]    a_col;
  logic [RowNW-1:0] phys_sum;
  logic [RW-1:0]    phys_row;
  logic [AW-1:0]    exec_addr;
  logic [AW-1:0]    base_addr;
  logic             move_ok;

  // memory write port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [15:0]      mem_wdata;

  logic is_put, is_read, is_move, is_clear;

  assign is_put   = item_q.kind == ttcw_pkg::KIND_PUT;
  assign is_read  = item_q.kind == ttcw_pkg::KIND_READ;
  assign is_move  = item_q.kind == ttcw_pkg::KIND_MOVE;
  assign is_clear = item_q.kind == ttcw_pkg::KIND_CLEAR;

  assign cur_attr = {bg_q, fg_q[3] | bold_q, fg_q[2:0]};

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q   <= ttcw_pkg::FG_RESET;
      bg_q   <= ttcw_pkg::BG_RESET;
      bold_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttcw_pkg::CFG_FG:   fg_q   <= cfg_data_i;
        ttcw_pkg::CFG_BG:   bg_q   <= cfg_data_i;
        ttcw_pkg::CFG_BOLD: bold_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control bytes, printable write and wrap
  always_comb begin
    put_row_n = {1'b0, cur_row_q};
    put_col_n = {1'b0, cur_col_q};
    put_we    = 1'b0;
    put_wcol  = cur_col_q;
    put_code  = item_q.char_code;
    case (item_q.char_code)
      ttcw_pkg::CODE_LF: begin
        put_col_n = '0;
        put_row_n = {1'b0, cur_row_q} + RowNW'(1);
      end
      ttcw_pkg::CODE_CR: put_col_n = '0;
      ttcw_pkg::CODE_TAB: begin
        put_col_n = ({1'b0, cur_col_q} + ColNW'(ttcw_pkg::TabStep))
                    & ~ColNW'(ttcw_pkg::TabStep - 1);
      end
      ttcw_pkg::CODE_BS: begin
        if (cur_col_q != '0) begin
          put_col_n = {1'b0, cur_col_q} - ColNW'(1);
          put_wcol  = cur_col_q - CW'(1);
          put_we    = 1'b1;
          put_code  = ttcw_pkg::BLANK_CODE;
        end
      end
      default: begin
        put_we    = 1'b1;
        put_col_n = {1'b0, cur_col_q} + ColNW'(1);
      end
    endcase
    if (put_col_n >= ColNW'(COLUMNS)) begin
      put_col_n = '0;
      put_row_n = put_row_n + RowNW'(1);
    end
    put_scroll = put_row_n >= RowNW'(ROWS);
  end

  // read clamp and move range check
  assign rd_row  = ({1'b0, item_q.target_row} >= 6'(ROWS)) ? RW'(ROWS - 1)
                                                          : item_q.target_row[RW-1:0];
  assign rd_col  = ({1'b0, item_q.target_col} >= 8'(COLUMNS)) ? CW'(COLUMNS - 1)
                                                             : item_q.target_col[CW-1:0];
  assign move_ok = ({1'b0, item_q.target_row} < 6'(ROWS))
                && ({1'b0, item_q.target_col} < 8'(COLUMNS));

  // logical row to memory row through the circular base
  assign a_row     = is_read ? rd_row : cur_row_q;
  assign a_col     = is_read ? rd_col : put_wcol;
  assign phys_sum  = {1'b0, a_row} + {1'b0, base_q};
  assign phys_row  = (phys_sum >= RowNW'(ROWS)) ? RW'(phys_sum - RowNW'(ROWS))
                                                : phys_sum[RW-1:0];
  assign exec_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(a_col);
  assign base_addr = AW'(base_q) * AW'(COLUMNS);

  // memory write selection: sweep blanks or character write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = exec_addr;
    mem_wdata = {attr_q, put_code};
    if (cmd_i.sweep) begin
      mem_we    = 1'b1;
      mem_waddr = ptr_q;
      mem_wdata = {attr_q, ttcw_pkg::BLANK_CODE};
    end else if (cmd_i.exec && is_put && put_we) begin
      mem_we = 1'b1;
    end
  end

  // cell memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.exec) rd_q <= mem[exec_addr];
  end

  // word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_data_i;
  end

  // cursor, scroll state and sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ttcw_pkg::ATTR_RESET;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      scroll_q    <= '0;
      base_q      <= '0;
      ptr_q       <= '0;
      sweep_end_q <= AW'(CellCount - 1);
    end else begin
      if (cmd_i.accept) attr_q <= cur_attr;
      if (cmd_i.sweep) ptr_q <= ptr_q + AW'(1);
      if (cmd_i.exec) begin
        if (is_put) begin
          cur_col_q <= put_col_n[CW-1:0];
          if (put_scroll) begin
            cur_row_q   <= RW'(ROWS - 1);
            base_q      <= (base_q == RW'(ROWS - 1)) ? '0 : base_q + RW'(1);
            ptr_q       <= base_addr;
            sweep_end_q <= base_addr + AW'(COLUMNS - 1);
            if (scroll_q < 8'(SCROLL_LIMIT)) scroll_q <= scroll_q + 8'd1;
          end else begin
            cur_row_q <= put_row_n[RW-1:0];
          end
        end else if (is_move) begin
          if (move_ok) begin
            cur_row_q <= item_q.target_row[RW-1:0];
            cur_col_q <= item_q.target_col[CW-1:0];
          end
        end else if (is_clear) begin
          cur_row_q   <= '0;
          cur_col_q   <= '0;
          scroll_q    <= '0;
          base_q      <= '0;
          ptr_q       <= '0;
          sweep_end_q <= AW'(CellCount - 1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.cursor_row     <= 5'(cur_row_q);
      out_q.cursor_col     <= 7'(cur_col_q);
      out_q.scroll_count   <= scroll_q;
      out_q.cell_code      <= is_read ? rd_q[7:0] : 8'd0;
      out_q.cell_attribute <= is_read ? rd_q[15:8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;
  assign status_o.need_sweep = is_clear || (is_put && put_scroll);
  assign status_o.sweep_last = ptr_q == sweep_end_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // cursor stays inside the region
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_row_q} < RowNW'(ROWS)) && ({1'b0, cur_col_q} < ColNW'(COLUMNS)))
    else $error("cursor outside the region");

  // a scroll parks the cursor on the last row and blanks exactly one row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && is_put && put_scroll |=>
      cur_row_q == RW'(ROWS - 1) && (sweep_end_q - ptr_q) == AW'(COLUMNS - 1))
    else $error("scroll set up wrongly");

  // sweep pointer never runs past its end
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep |-> ptr_q <= sweep_end_q)
    else $error("sweep pointer past end");

  // only reads return cell contents
  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && !is_read |=>
      out_q.cell_code == 8'd0 && out_q.cell_attribute == 8'd0)
    else $error("cell fields set for a non-read word");

endmodule

// ===== hdl/text_terminal_character_writer.sv =====
// top level of the text terminal character writer
// instantiates ttcw_ctrl and ttcw_dp; uses ttcw_pkg and ttcw_stream_if
//
//   channel   direction  payload               handshake
//   in_i      sink       ttcw_pkg::in_word_t   valid/ready
//   out_o     source     ttcw_pkg::out_word_t  valid/ready
//   cfg       sink       index + 4-bit data    write enable, no back-pressure
//
// put, read and move each go through accept, execute on the cell memory
// port, load the output register.
// a put that scrolls adds a sweep with one blank write per cell of the recycled row.
// clear adds a sweep with one memory write per cell.
// after reset a clearing pass over every cell runs before the first word is taken.
// a new word is taken while the previous result waits in the output register.
module text_terminal_character_writer #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 21,
  parameter int SCROLL_LIMIT = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ttcw_stream_if.sink                   in_i,
  ttcw_stream_if.source                 out_o,
  input  logic                          cfg_we_i,
  input  logic [ttcw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttcw_pkg::CfgDataW-1:0] cfg_data_i
);

  ttcw_pkg::cmd_t      cmd;
  ttcw_pkg::status_t   status;
  ttcw_pkg::in_word_t  in_word;
  ttcw_pkg::out_word_t out_word;
  logic                in_ready;
  logic                out_valid;

  assign in_word = in_i.data;

  // sequencing
  ttcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  ttcw_dp #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .SCROLL_LIMIT (SCROLL_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_word),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_word),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_word;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for text_terminal_character_writer
// holds its own copy of the screen, cursor and scroll count and checks every status word
// depends on ttcw_pkg, ttcw_stream_if and the block under test
module tb_top;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 21;
  localparam int SCROLL_LIMIT = 255;
  localparam int LAST_ROW     = ROWS - 1;
  localparam int LAST_COL     = COLUMNS - 1;

  typedef struct {
    ttcw_pkg::in_word_t  w;
    bit                  typed;
    ttcw_pkg::out_word_t want;
  } dir_case_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [ttcw_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [ttcw_pkg::CfgDataW-1:0] cfg_data;

  ttcw_stream_if #(.T(ttcw_pkg::in_word_t))  in_ch ();
  ttcw_stream_if #(.T(ttcw_pkg::out_word_t)) out_ch ();

  text_terminal_character_writer #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .SCROLL_LIMIT(SCROLL_LIMIT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // local copy of the terminal state
  logic [15:0] screen_copy [ROWS*COLUMNS];
  int          cur_row;
  int          cur_col;
  int          scroll_cnt;
  logic [3:0]  fg_reg;
  logic [3:0]  bg_reg;
  logic        bold_reg;

  ttcw_pkg::out_word_t pending_status [$];
  dir_case_t           dir_cases [$];
  int                  src_idle_pct;
  int                  snk_stall_pct;
  int                  errors;
  int                  words_sent;
  int                  words_checked;
  int                  clears_sent;
  int                  scroll_peak;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] text_attr();
    return {bg_reg, fg_reg[3] | bold_reg, fg_reg[2:0]};
  endfunction

  function automatic int cell_at(input int r, input int c);
    if (r >= ROWS) r = LAST_ROW;
    if (c >= COLUMNS) c = LAST_COL;
    return r * COLUMNS + c;
  endfunction

  function automatic void fill_blank();
    foreach (screen_copy[i]) screen_copy[i] = {text_attr(), ttcw_pkg::BLANK_CODE};
  endfunction

  // apply one word to the local state and return the status word it produces
  function automatic ttcw_pkg::out_word_t console_step(input ttcw_pkg::in_word_t w);
    ttcw_pkg::out_word_t o;
    int                  r;
    int                  c;
    logic [15:0]         cell_v;
    o = '0;
    case (w.kind)
      ttcw_pkg::KIND_PUT: begin
        r = cur_row;
        c = cur_col;
        case (w.char_code)
          ttcw_pkg::CODE_LF: begin
            c = 0;
            r++;
          end
          ttcw_pkg::CODE_CR: c = 0;
          ttcw_pkg::CODE_TAB: c = (c + ttcw_pkg::TabStep) & ~(ttcw_pkg::TabStep - 1);
          ttcw_pkg::CODE_BS: begin
            if (c > 0) begin
              c--;
              screen_copy[cell_at(r, c)] = {text_attr(), ttcw_pkg::BLANK_CODE};
            end
          end
          default: begin
            if (c < COLUMNS) begin
              screen_copy[cell_at(r, c)] = {text_attr(), w.char_code};
              c++;
            end
          end
        endcase
        // wrap at the right edge, then scroll past the bottom row
        if (c >= COLUMNS) begin
          c = 0;
          r++;
        end
        if (r >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_copy[i] = screen_copy[i + COLUMNS];
          for (int i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++)
            screen_copy[i] = {text_attr(), ttcw_pkg::BLANK_CODE};
          r = LAST_ROW;
          if (scroll_cnt < SCROLL_LIMIT) scroll_cnt++;
        end
        cur_row = r;
        cur_col = c;
      end
      ttcw_pkg::KIND_READ: begin
        cell_v = screen_copy[cell_at(int'(w.target_row), int'(w.target_col))];
        o.cell_code      = cell_v[7:0];
        o.cell_attribute = cell_v[15:8];
      end
      ttcw_pkg::KIND_MOVE: begin
        if (w.target_row < ROWS && w.target_col < COLUMNS) begin
          cur_row = int'(w.target_row);
          cur_col = int'(w.target_col);
        end
      end
      default: begin
        fill_blank();
        cur_row    = 0;
        cur_col    = 0;
        scroll_cnt = 0;
      end
    endcase
    if (scroll_cnt > scroll_peak) scroll_peak = scroll_cnt;
    o.cursor_row   = cur_row[4:0];
    o.cursor_col   = cur_col[6:0];
    o.scroll_count = scroll_cnt[7:0];
    return o;
  endfunction

  function automatic ttcw_pkg::out_word_t status_of(input int r, input int c, input int sc,
                                                    input logic [7:0] code,
                                                    input logic [7:0] attr);
    ttcw_pkg::out_word_t o;
    o.cursor_row     = r[4:0];
    o.cursor_col     = c[6:0];
    o.scroll_count   = sc[7:0];
    o.cell_code      = code;
    o.cell_attribute = attr;
    return o;
  endfunction

  function automatic ttcw_pkg::in_word_t noise_word();
    ttcw_pkg::in_word_t w;
    w.kind       = 2'($urandom_range(3));
    w.char_code  = 8'($urandom_range(255));
    w.target_row = 5'($urandom_range(31));
    w.target_col = 7'($urandom_range(127));
    return w;
  endfunction

  function automatic void add_case(input ttcw_pkg::kind_e k, input logic [7:0] code,
                                   input int r, input int c, input bit typed,
                                   input ttcw_pkg::out_word_t want);
    dir_case_t d;
    d.w.kind       = k;
    d.w.char_code  = code;
    d.w.target_row = r[4:0];
    d.w.target_col = c[6:0];
    d.typed        = typed;
    d.want         = want;
    dir_cases.push_back(d);
  endfunction

  // offer one word, with random idle cycles in front, and log its expected status
  task automatic send_word(input ttcw_pkg::in_word_t w, input bit typed,
                           input ttcw_pkg::out_word_t typed_want);
    ttcw_pkg::out_word_t model_out;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    model_out = console_step(w);
    if (w.kind == ttcw_pkg::KIND_CLEAR) clears_sent++;
    pending_status.push_back(typed ? typed_want : model_out);
    words_sent++;
  endtask

  // drain the block, then write all three color registers
  task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg, input logic bold);
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= ttcw_pkg::CFG_FG;
    cfg_data <= fg;
    @(posedge clk_i);
    cfg_idx  <= ttcw_pkg::CFG_BG;
    cfg_data <= bg;
    @(posedge clk_i);
    cfg_idx  <= ttcw_pkg::CFG_BOLD;
    cfg_data <= {3'b000, bold};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    fg_reg   = fg;
    bg_reg   = bg;
    bold_reg = bold;
  endtask

  // random traffic built from text runs, line feeds, reads, moves, control bytes, random words and clears
  task automatic random_phase(input int n);
    int                 sent;
    int                 pick;
    int                 len;
    ttcw_pkg::in_word_t w;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(1, 20);
        repeat (len) begin
          w = noise_word();
          w.kind = ttcw_pkg::KIND_PUT;
          if ($urandom_range(9) < 8) w.char_code = 8'($urandom_range(8'h7E, 8'h20));
          send_word(w, 1'b0, '0);
          sent++;
        end
      end else if (pick < 60) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          w = noise_word();
          w.kind      = ttcw_pkg::KIND_PUT;
          w.char_code = ttcw_pkg::CODE_LF;
          send_word(w, 1'b0, '0);
          sent++;
        end
      end else if (pick < 72) begin
        w = noise_word();
        w.kind = ttcw_pkg::KIND_READ;
        // half the time look at the row being written
        if ($urandom_range(1) == 0) begin
          w.target_row = cur_row[4:0];
          w.target_col = 7'($urandom_range(LAST_COL));
        end else if ($urandom_range(9) < 6) begin
          w.target_row = 5'($urandom_range(LAST_ROW));
          w.target_col = 7'($urandom_range(LAST_COL));
        end
        send_word(w, 1'b0, '0);
        sent++;
      end else if (pick < 84) begin
        w = noise_word();
        w.kind = ttcw_pkg::KIND_MOVE;
        if ($urandom_range(3) != 0) begin
          w.target_row = 5'($urandom_range(LAST_ROW));
          w.target_col = 7'($urandom_range(LAST_COL));
        end
        send_word(w, 1'b0, '0);
        sent++;
      end else if (pick < 94) begin
        w = noise_word();
        w.kind = ttcw_pkg::KIND_PUT;
        case ($urandom_range(2))
          0: w.char_code = ttcw_pkg::CODE_BS;
          1: w.char_code = ttcw_pkg::CODE_TAB;
          default: w.char_code = ttcw_pkg::CODE_CR;
        endcase
        send_word(w, 1'b0, '0);
        sent++;
      end else if (pick < 97) begin
        send_word(noise_word(), 1'b0, '0);
        sent++;
      end else begin
        w = noise_word();
        w.kind = ttcw_pkg::KIND_CLEAR;
        send_word(w, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // compare one field of a status word
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // result side: check accepted status words, stall at random
  always @(posedge clk_i) begin : status_check
    ttcw_pkg::out_word_t want_w;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: status word with none expected, expected nothing got %h",
                 $time, out_ch.data);
      end else begin
        want_w = pending_status.pop_front();
        words_checked++;
        check_field("cursor_row", 8'(want_w.cursor_row), 8'(out_ch.data.cursor_row));
        check_field("cursor_col", 8'(want_w.cursor_col), 8'(out_ch.data.cursor_col));
        check_field("scroll_count", want_w.scroll_count, out_ch.data.scroll_count);
        check_field("cell_code", want_w.cell_code, out_ch.data.cell_code);
        check_field("cell_attribute", want_w.cell_attribute, out_ch.data.cell_attribute);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // stimulus
  initial begin : stimulus
    ttcw_pkg::in_word_t w;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= ttcw_pkg::CFG_FG;
    cfg_data      <= '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    errors        = 0;
    words_sent    = 0;
    words_checked = 0;
    clears_sent   = 0;
    scroll_peak   = 0;
    fg_reg        = ttcw_pkg::FG_RESET;
    bg_reg        = ttcw_pkg::BG_RESET;
    bold_reg      = 1'b0;
    cur_row       = 0;
    cur_col       = 0;
    scroll_cnt    = 0;
    fill_blank();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, control bytes, edges, wrap, scroll, clear
    add_case(ttcw_pkg::KIND_READ, 8'h00, 0, 0, 1'b1,
             status_of(0, 0, 0, ttcw_pkg::BLANK_CODE, ttcw_pkg::ATTR_RESET));
    add_case(ttcw_pkg::KIND_READ, 8'hFF, 31, 127, 1'b1,
             status_of(0, 0, 0, ttcw_pkg::BLANK_CODE, ttcw_pkg::ATTR_RESET));
    add_case(ttcw_pkg::KIND_PUT, 8'h41, 0, 0, 1'b1, status_of(0, 1, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_READ, 8'h00, 0, 0, 1'b1,
             status_of(0, 1, 0, 8'h41, ttcw_pkg::ATTR_RESET));
    add_case(ttcw_pkg::KIND_PUT, 8'hFF, 31, 127, 1'b1, status_of(0, 2, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, 8'h00, 0, 0, 1'b1, status_of(0, 3, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, ttcw_pkg::CODE_BS, 0, 0, 1'b1,
             status_of(0, 2, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_READ, 8'h00, 0, 2, 1'b1,
             status_of(0, 2, 0, ttcw_pkg::BLANK_CODE, ttcw_pkg::ATTR_RESET));
    add_case(ttcw_pkg::KIND_PUT, ttcw_pkg::CODE_TAB, 0, 0, 1'b1,
             status_of(0, 8, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, ttcw_pkg::CODE_CR, 0, 0, 1'b1,
             status_of(0, 0, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, ttcw_pkg::CODE_BS, 0, 0, 1'b1,
             status_of(0, 0, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, ttcw_pkg::CODE_LF, 0, 0, 1'b1,
             status_of(1, 0, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_MOVE, 8'h00, 31, 127, 1'b1, status_of(1, 0, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_MOVE, 8'h00, ROWS, 0, 1'b1, status_of(1, 0, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_MOVE, 8'h00, 0, COLUMNS, 1'b1, status_of(1, 0, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_MOVE, 8'h00, LAST_ROW, LAST_COL, 1'b1,
             status_of(LAST_ROW, LAST_COL, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, 8'h5A, 0, 0, 1'b1, status_of(LAST_ROW, 0, 1, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_READ, 8'h00, LAST_ROW - 1, LAST_COL, 1'b1,
             status_of(LAST_ROW, 0, 1, 8'h5A, ttcw_pkg::ATTR_RESET));
    add_case(ttcw_pkg::KIND_READ, 8'h00, LAST_ROW, LAST_COL, 1'b1,
             status_of(LAST_ROW, 0, 1, ttcw_pkg::BLANK_CODE, ttcw_pkg::ATTR_RESET));
    add_case(ttcw_pkg::KIND_MOVE, 8'h00, LAST_ROW, 72, 1'b1,
             status_of(LAST_ROW, 72, 1, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, ttcw_pkg::CODE_TAB, 0, 0, 1'b1,
             status_of(LAST_ROW, 0, 2, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, ttcw_pkg::CODE_LF, 0, 0, 1'b1,
             status_of(LAST_ROW, 0, 3, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_MOVE, 8'h00, 10, 40, 1'b1, status_of(10, 40, 3, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_PUT, 8'h7E, 0, 0, 1'b0, '0);
    add_case(ttcw_pkg::KIND_CLEAR, 8'h00, 0, 0, 1'b1, status_of(0, 0, 0, 8'h00, 8'h00));
    add_case(ttcw_pkg::KIND_READ, 8'h00, 10, 40, 1'b1,
             status_of(0, 0, 0, ttcw_pkg::BLANK_CODE, ttcw_pkg::ATTR_RESET));
    foreach (dir_cases[i]) send_word(dir_cases[i].w, dir_cases[i].typed, dir_cases[i].want);

    // no idling, brightest attribute, then enough line feeds to saturate the scroll count
    set_colors(4'hF, 4'hF, 1'b1);
    w = noise_word();
    w.kind       = ttcw_pkg::KIND_MOVE;
    w.target_row = 5'(LAST_ROW);
    w.target_col = 7'($urandom_range(LAST_COL));
    send_word(w, 1'b0, '0);
    repeat (SCROLL_LIMIT + 15) begin
      w = noise_word();
      w.kind      = ttcw_pkg::KIND_PUT;
      w.char_code = ttcw_pkg::CODE_LF;
      send_word(w, 1'b0, '0);
    end
    random_phase(265);

    // sender mostly idle, all-zero attribute
    set_colors(4'h0, 4'h0, 1'b0);
    src_idle_pct = 78;
    random_phase(265);

    // receiver mostly stalled
    set_colors(4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)));
    src_idle_pct  = 0;
    snk_stall_pct = 78;
    random_phase(265);

    // light idling on both sides
    set_colors(4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)));
    src_idle_pct  = 8;
    snk_stall_pct = 8;
    random_phase(265);

    // wait for the last status words
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d words sent, %0d status words checked, %0d clears",
             words_sent, words_checked, clears_sent);
    $display("tb: scroll count peaked at %0d under four idle/stall mixes and four color sets",
             scroll_peak);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ttcw_pkg.sv
hdl/ttcw_stream_if.sv
hdl/ttcw_ctrl.sv
hdl/ttcw_dp.sv
hdl/text_terminal_character_writer.sv
tb/tb_top.sv
